FILE: rtl/two_speed_channel_smoothing_filter_defines.svh
// Assertion macros for the two-speed channel smoothing filter.
`ifndef TWO_SPEED_CHANNEL_SMOOTHING_FILTER_DEFINES_SVH
`define TWO_SPEED_CHANNEL_SMOOTHING_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define TSCF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tscf assertion failed");
`define TSCF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tscf assertion failed");
`else
`define TSCF_ASSERT(lbl, clk, rst, prop)
`define TSCF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/tscf_pkg.sv
// Shared constants and state encoding of the two-speed channel smoothing filter.
package tscf_pkg;

   localparam int CHANNELS   = 16;
   localparam int CHANNEL_W  = 4;
   localparam int SAMPLE_W   = 16;
   localparam int STRENGTH_W = 8;
   localparam int LEVEL_IDX_W = $clog2(CHANNELS);
   localparam int PROD_W     = SAMPLE_W + STRENGTH_W;
   localparam int DIVISOR_W  = STRENGTH_W + 1;
   localparam int MUL_CNT_W  = $clog2(STRENGTH_W + 1);
   localparam int DIV_CNT_W  = $clog2(SAMPLE_W + 1);

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

FILE: rtl/tscf_if.sv
// Request and response channel interfaces of the two-speed channel smoothing filter.
interface tscf_req_if;
   logic                                valid;
   logic                                ready;
   logic [tscf_pkg::CHANNEL_W-1:0]      channel;
   logic [tscf_pkg::SAMPLE_W-1:0]       sample;
   logic [tscf_pkg::STRENGTH_W-1:0]     strength;

   modport source (output valid, output channel, output sample, output strength,
                   input ready);
   modport sink (input valid, input channel, input sample, input strength,
                 output ready);
endinterface

interface tscf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tscf_pkg::SAMPLE_W-1:0]       filtered;

   modport source (output valid, output filtered, input ready);
   modport sink (input valid, input filtered, output ready);
endinterface

FILE: rtl/tscf_serial_mul.sv
// Bit-serial shift-and-add multiplier that forms level * strength + sample.
module tscf_serial_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tscf_pkg::SAMPLE_W-1:0]       level,
   input  logic [tscf_pkg::STRENGTH_W-1:0]     weight,
   input  logic [tscf_pkg::SAMPLE_W-1:0]       addend,
   output logic                                done,
   output logic [tscf_pkg::PROD_W-1:0]         product
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [tscf_pkg::MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [tscf_pkg::PROD_W-1:0]         acc_ff, acc_in;
   logic [tscf_pkg::PROD_W-1:0]         mcand_ff, mcand_in;
   logic [tscf_pkg::STRENGTH_W-1:0]     mplier_ff, mplier_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = tscf_pkg::MUL_CNT_W'(tscf_pkg::STRENGTH_W);
         acc_in    = tscf_pkg::PROD_W'(addend);
         mcand_in  = tscf_pkg::PROD_W'(level);
         mplier_in = weight;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[tscf_pkg::PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[tscf_pkg::STRENGTH_W-1:1]};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == tscf_pkg::MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: rtl/tscf_serial_div.sv
// Restoring divider that produces one quotient bit per cycle.
module tscf_serial_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tscf_pkg::PROD_W-1:0]         dividend,
   input  logic [tscf_pkg::DIVISOR_W-1:0]      divisor,
   output logic                                done,
   output logic [tscf_pkg::SAMPLE_W-1:0]       quotient
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [tscf_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [tscf_pkg::DIVISOR_W-1:0]      rem_ff, rem_in;
   logic [tscf_pkg::SAMPLE_W-1:0]       quo_ff, quo_in;
   logic [tscf_pkg::DIVISOR_W-1:0]      den_ff, den_in;
   logic [tscf_pkg::DIVISOR_W:0]        trial;
   logic                                fits;

   // The quotient always fits the sample width, so the dividend's upper bits
   // start out as a remainder that is already below the divisor.
   always_comb begin
      trial     = {rem_ff, quo_ff[tscf_pkg::SAMPLE_W-1]};
      fits      = (trial >= {1'b0, den_ff});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = tscf_pkg::DIV_CNT_W'(tscf_pkg::SAMPLE_W);
         rem_in  = tscf_pkg::DIVISOR_W'(dividend[tscf_pkg::PROD_W-1:tscf_pkg::SAMPLE_W]);
         quo_in  = dividend[tscf_pkg::SAMPLE_W-1:0];
         den_in  = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = tscf_pkg::DIVISOR_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[tscf_pkg::DIVISOR_W-1:0];
         end
         quo_in = {quo_ff[tscf_pkg::SAMPLE_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tscf_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/two_speed_channel_smoothing_filter.sv
// Top level of the two-speed channel smoothing filter: level store, control and response register.
// Each request beat updates the stored level of one channel and returns it in one response beat.
// When the sample differs from the level by at least the threshold register, the level moves
// halfway toward the sample. Otherwise the new level is (level * strength + sample) /
// (strength + 1), formed by a bit-serial multiplier of eight steps and a restoring divider of
// sixteen steps. One beat is processed at a time; a new request is taken while the previous
// response still waits. All channel levels are zero after reset and the threshold is 100.
`include "two_speed_channel_smoothing_filter_defines.svh"

module two_speed_channel_smoothing_filter (
   input  logic                                clock,
   input  logic                                reset,
   tscf_req_if.sink                            req,
   tscf_rsp_if.source                          rsp,
   input  logic                                csr_wr_en,
   input  logic [tscf_pkg::SAMPLE_W-1:0]       csr_wr_data
);

   tscf_pkg::state_type                 state_ff, state_in;

   logic [tscf_pkg::SAMPLE_W-1:0]       threshold_ff;
   logic [tscf_pkg::SAMPLE_W-1:0]       level_ff [tscf_pkg::CHANNELS];

   logic [tscf_pkg::LEVEL_IDX_W-1:0]    idx_ff;
   logic                                in_range_ff;
   logic [tscf_pkg::SAMPLE_W-1:0]       sample_ff;
   logic [tscf_pkg::STRENGTH_W-1:0]     strength_ff;
   logic [tscf_pkg::SAMPLE_W-1:0]       old_level_ff;
   logic signed [tscf_pkg::SAMPLE_W:0]  delta_ff;
   logic [tscf_pkg::SAMPLE_W-1:0]       result_ff;

   logic                                rsp_valid_ff;
   logic [tscf_pkg::SAMPLE_W-1:0]       rsp_data_ff;

   logic                                accept;
   logic                                in_range;
   logic [tscf_pkg::SAMPLE_W-1:0]       read_level;
   logic [tscf_pkg::SAMPLE_W:0]         mag;
   logic                                coarse;
   logic [tscf_pkg::SAMPLE_W+1:0]       half_sum;

   logic                                mul_start;
   logic                                mul_done;
   logic [tscf_pkg::PROD_W-1:0]         product;
   logic                                div_start;
   logic                                div_done;
   logic [tscf_pkg::SAMPLE_W-1:0]       quotient;
   logic                                commit;

   assign accept     = req.valid && req.ready;
   assign in_range   = (int'(req.channel) < tscf_pkg::CHANNELS);
   assign read_level = level_ff[req.channel[tscf_pkg::LEVEL_IDX_W-1:0]];

   assign mag      = delta_ff[tscf_pkg::SAMPLE_W] ? (~delta_ff + 1'b1) : delta_ff;
   assign coarse   = (mag >= {1'b0, threshold_ff});
   assign half_sum = {2'b00, old_level_ff}
                     + {{2{delta_ff[tscf_pkg::SAMPLE_W]}}, delta_ff[tscf_pkg::SAMPLE_W:1]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tscf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = in_range ? tscf_pkg::ST_DECIDE : tscf_pkg::ST_FINISH;
            end
         end
         tscf_pkg::ST_DECIDE: begin
            state_in = coarse ? tscf_pkg::ST_FINISH : tscf_pkg::ST_MUL;
         end
         tscf_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = tscf_pkg::ST_DIV;
            end
         end
         tscf_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = tscf_pkg::ST_FINISH;
            end
         end
         tscf_pkg::ST_FINISH: begin
            if (commit) begin
               state_in = tscf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tscf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req.ready = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         tscf_pkg::ST_IDLE: begin
            req.ready = 1'b1;
         end
         tscf_pkg::ST_DECIDE: begin
            mul_start = !coarse;
         end
         tscf_pkg::ST_MUL: begin
            div_start = mul_done;
         end
         tscf_pkg::ST_FINISH: begin
            commit = !rsp_valid_ff || rsp.ready;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   tscf_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .level   (old_level_ff),
      .weight  (strength_ff),
      .addend  (sample_ff),
      .done    (mul_done),
      .product (product)
   );

   tscf_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  ({1'b0, strength_ff} + 1'b1),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tscf_pkg::ST_IDLE;
         threshold_ff <= tscf_pkg::THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
         in_range_ff  <= 1'b0;
         for (int i = 0; i < tscf_pkg::CHANNELS; i++) begin
            level_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         if (accept) begin
            in_range_ff <= in_range;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (commit && in_range_ff) begin
            level_ff[idx_ff] <= result_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff       <= req.channel[tscf_pkg::LEVEL_IDX_W-1:0];
         sample_ff    <= req.sample;
         strength_ff  <= req.strength;
         old_level_ff <= read_level;
         delta_ff     <= $signed({1'b0, req.sample}) - $signed({1'b0, read_level});
         result_ff    <= '0;
      end else if (state_ff == tscf_pkg::ST_DECIDE && coarse) begin
         result_ff <= half_sum[tscf_pkg::SAMPLE_W-1:0];
      end else if (div_done) begin
         result_ff <= quotient;
      end
      if (commit) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.filtered = rsp_data_ff;

   `TSCF_ASSERT(a_mul_done_in_mul, clock, reset, mul_done |-> state_ff == tscf_pkg::ST_MUL)
   `TSCF_ASSERT(a_div_done_in_div, clock, reset, div_done |-> state_ff == tscf_pkg::ST_DIV)
   `TSCF_ASSERT(a_commit_shows_beat, clock, reset, commit |=> rsp_valid_ff)
   `TSCF_ASSERT(a_accept_leaves_idle, clock, reset, accept |=> state_ff != tscf_pkg::ST_IDLE)
   `TSCF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> state_ff == tscf_pkg::ST_IDLE && !rsp_valid_ff)

endmodule
